>>> rtl/scc_pkg.sv
// Shared types and constants of the sector cache clock replacement unit.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int IDX_W       = 6;
  localparam int SECTOR_W    = 32;
  localparam int CHANCES_W   = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CHANCES_W-1:0] CHANCES_RESET = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RELOAD_COUNT     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_ROBIN_MODE = 1'b1;

  // Request type codes.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SECTOR_W-1:0] sector_number;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    entry_index;
    logic                hit;
    logic                writeback_needed;
    logic [SECTOR_W-1:0] writeback_sector;
  } res_t;

  // Per-entry metadata held in the metadata memory.
  typedef struct packed {
    logic                 dirty;
    logic [CHANCES_W-1:0] usage;
  } meta_t;

endpackage

`default_nettype wire

>>> rtl/sector_cache_clock_replacement_unit.sv
// Top level of the sector cache tag and clock replacement controller.
// The hand may pass over at most 3*ENTRIES entries on a miss, and none in round-robin mode.
// The next start is taken while done is high.
// The tag search reads one tag memory word per cycle; each step of the hand is a
// read-modify-write of the metadata memory. Synchronous reset clears the valid bits and
// the hand and returns the state, configuration registers, done and search flags to
// their reset values; done cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_clock_replacement_unit #(
  parameter int ENTRIES     = 64,
  parameter int SECTOR_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [scc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [scc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              start,
  input  wire scc_pkg::req_t                     req,
  output logic                                   busy,
  output logic                                   done,
  output scc_pkg::res_t                          result
);

  import scc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_HIT_RD,
    S_HIT_WR,
    S_SWP_RD,
    S_SWP_EV,
    S_VIC_RD,
    S_VIC_WR
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CHANCES_W-1:0] reload_count;
  logic                 round_robin_mode;

  // Request held for the whole of its handling.
  logic                   is_write;
  logic [SECTOR_BITS-1:0] sector;

  // Search sweep: scan issues tag reads, and cmp_* is registered from it to line up with the read data.
  logic [AW-1:0] scan;
  logic          issue;
  logic          cmp_valid;
  logic [AW-1:0] cmp_addr;

  logic [AW-1:0] hand;
  logic [AW-1:0] hand_next;
  logic [AW-1:0] victim;
  logic          vic_dirty;
  logic [ENTRIES-1:0] valid;

  // Memory ports.
  logic                   tag_we;
  logic [AW-1:0]          tag_raddr;
  logic [SECTOR_BITS-1:0] tag_rdata;
  logic                   meta_we;
  logic [AW-1:0]          meta_waddr;
  meta_t                  meta_wdata;
  logic [AW-1:0]          meta_raddr;
  meta_t                  meta_rdata;

  logic                   tag_match;
  logic                   hand_valid;
  logic [CHANCES_W-1:0]   hand_usage;
  logic [AW+IDX_W-1:0]    victim_wide;
  logic [SECTOR_BITS+SECTOR_W-1:0] tag_wide;

  scc_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (victim),
    .wdata (sector),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  scc_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (ENTRIES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  assign busy = (state != S_IDLE);

  // A tag is only trusted when its valid bit is set, so the unwritten tag memory is harmless.
  assign tag_match = cmp_valid && valid[cmp_addr] && (tag_rdata == sector);

  // An entry that has never been filled reads as clean with a zero usage count.
  assign hand_valid = valid[hand];
  assign hand_usage = hand_valid ? meta_rdata.usage : '0;
  assign hand_next  = (hand == LAST) ? '0 : hand + 1'b1;

  assign victim_wide = {{IDX_W{1'b0}}, victim};
  assign tag_wide    = {{SECTOR_W{1'b0}}, tag_rdata};

  // Read address selection: the search walks the scan counter, the sweep the hand, everything else the victim.
  assign tag_raddr  = (state == S_SEARCH) ? scan : victim;
  assign meta_raddr = (state == S_SWP_RD) ? hand : victim;
  assign tag_we     = (state == S_VIC_WR);

  // Metadata writes: a hit reloads the count and keeps the dirty bit, setting it on a write, the sweep
  // decrements a count it passes over, and a fill starts a fresh entry.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = victim;
    meta_wdata = '0;
    unique case (state)
      S_HIT_WR: begin
        meta_we          = 1'b1;
        meta_wdata.dirty = meta_rdata.dirty | is_write;
        meta_wdata.usage = reload_count;
      end
      S_SWP_EV: begin
        meta_we          = !round_robin_mode && (hand_usage != '0);
        meta_waddr       = hand;
        meta_wdata.dirty = meta_rdata.dirty;
        meta_wdata.usage = hand_usage - 1'b1;
      end
      S_VIC_WR: begin
        meta_we          = 1'b1;
        meta_wdata.dirty = is_write;
        meta_wdata.usage = reload_count;
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      reload_count     <= CHANCES_RESET;
      round_robin_mode <= 1'b0;
      hand             <= '0;
      valid            <= '0;
      done             <= 1'b0;
      issue            <= 1'b0;
      cmp_valid        <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_RELOAD_COUNT:     reload_count     <= cfg_wdata;
          CFG_ROUND_ROBIN_MODE: round_robin_mode <= cfg_wdata[0];
          default:              reload_count     <= reload_count;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            is_write  <= (req.req_type == REQ_WRITE);
            sector    <= req.sector_number[SECTOR_BITS-1:0];
            scan      <= '0;
            issue     <= 1'b1;
            cmp_valid <= 1'b0;
            state     <= S_SEARCH;
          end
        end

        S_SEARCH: begin
          cmp_valid <= issue;
          cmp_addr  <= scan;
          if (issue) begin
            if (scan == LAST) begin
              issue <= 1'b0;
            end else begin
              scan <= scan + 1'b1;
            end
          end
          // The first match in address order wins.
          if (tag_match) begin
            victim <= cmp_addr;
            issue  <= 1'b0;
            state  <= S_HIT_RD;
          end else if (cmp_valid && (cmp_addr == LAST)) begin
            issue <= 1'b0;
            state <= S_SWP_RD;
          end
        end

        S_HIT_RD: begin
          state <= S_HIT_WR;
        end

        S_HIT_WR: begin
          result.entry_index      <= victim_wide[IDX_W-1:0];
          result.hit              <= 1'b1;
          result.writeback_needed <= 1'b0;
          result.writeback_sector <= '0;
          done                    <= 1'b1;
          state                   <= S_IDLE;
        end

        S_SWP_RD: begin
          state <= S_SWP_EV;
        end

        S_SWP_EV: begin
          hand <= hand_next;
          if (!round_robin_mode && (hand_usage != '0)) begin
            state <= S_SWP_RD;
          end else begin
            victim    <= hand;
            vic_dirty <= hand_valid && meta_rdata.dirty;
            state     <= S_VIC_RD;
          end
        end

        S_VIC_RD: begin
          state <= S_VIC_WR;
        end

        S_VIC_WR: begin
          valid[victim]           <= 1'b1;
          result.entry_index      <= victim_wide[IDX_W-1:0];
          result.hit              <= 1'b0;
          result.writeback_needed <= vic_dirty;
          result.writeback_sector <= vic_dirty ? tag_wide[SECTOR_W-1:0] : '0;
          done                    <= 1'b1;
          state                   <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/scc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
